/* rtl/uwdf_pkg.sv */
package uwdf_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int BYTE_CNT_W  = $clog2(FRAME_BYTES);

	localparam logic [7:0] SYNC_BYTE  = 8'h05;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] WRITE_FLAG = 8'h80;
	localparam logic [7:0] CRC_INIT   = 8'h00;

	// Fields of one finished frame, handed from the CRC pipeline to the serializer.
	typedef struct packed {
		logic [7:0]  node_address;
		logic [6:0]  register_address;
		logic [31:0] write_data;
		logic [7:0]  crc;
	} frame_t;

	// One byte into the CRC, bits taken least significant first into a
	// left-shifting register.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
		input logic [7:0] data_in);
		logic [7:0] c;
		logic [7:0] d;
		c = crc_in;
		d = data_in;
		for (int k = 0; k < 8; k++) begin
			if (c[7] ^ d[0]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
			d = {1'b0, d[7:1]};
		end
		return c;
	endfunction

endpackage

/* rtl/uwdf_ser.sv */
module uwdf_ser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	input  uwdf_pkg::frame_t    load_frame,
	output logic                load_ready,
	output logic                frame_valid,
	input  logic                frame_stall,
	output logic [7:0]          frame_byte,
	output logic                last_byte
);
	import uwdf_pkg::*;

	localparam int SREG_W = FRAME_BYTES * 8;

	logic [SREG_W-1:0]     sreg_q;
	logic [BYTE_CNT_W-1:0] cnt_q;
	logic                  valid_q;
	logic                  take;
	logic                  at_last;
	logic                  load;
	logic [SREG_W-1:0]     frame_vec;

	assign take       = valid_q && !frame_stall;
	assign at_last    = (cnt_q == BYTE_CNT_W'(FRAME_BYTES - 1));
	// A new frame may load in the same cycle that the last byte of the old one leaves.
	assign load_ready = !valid_q || (take && at_last);
	assign load       = load_valid && load_ready;

	assign frame_vec = {SYNC_BYTE, load_frame.node_address,
		WRITE_FLAG | {1'b0, load_frame.register_address},
		load_frame.write_data, load_frame.crc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				cnt_q   <= '0;
			end else if (take) begin
				if (at_last) begin
					valid_q <= 1'b0;
				end
				cnt_q <= cnt_q + BYTE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sreg_q <= frame_vec;
		end else if (take) begin
			sreg_q <= {sreg_q[SREG_W-9:0], 8'h00};
		end
	end

	assign frame_valid = valid_q;
	assign frame_byte  = sreg_q[SREG_W-1 -: 8];
	assign last_byte   = at_last;

endmodule

/* rtl/uart_write_datagram_framer.sv */
// Path: an accepted request beat passes the CRC stages s1, s2 and s3 and is then
// loaded into the serializer, which offers the frame's bytes in order up to the CRC byte.
// The byte-wide output serializer holds one frame while its bytes go out; the three
// CRC stages before it let the next request move up while bytes go out.
// Reset (arst_n low, asynchronous): all pipeline valid bits and the serializer's valid
// bit and byte counter clear, and node_address returns to 0.
module uart_write_datagram_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [6:0]  register_address,
	input  logic [31:0] write_data,
	output logic        frame_valid,
	input  logic        frame_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);
	import uwdf_pkg::*;

	logic [7:0]  node_address_q;

	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	logic [6:0]  addr_s1;
	logic [6:0]  addr_s2;
	logic [6:0]  addr_s3;
	logic [31:0] data_s1;
	logic [31:0] data_s2;
	logic [31:0] data_s3;
	logic [7:0]  node_s1;
	logic [7:0]  node_s2;
	logic [7:0]  node_s3;
	logic [7:0]  crc_s1;
	logic [7:0]  crc_s2;
	logic [7:0]  crc_s3;

	logic        en1;
	logic        en2;
	logic        en3;
	logic        load_ready;
	frame_t      load_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= 8'h00;
		end else if (cfg_wr_en) begin
			node_address_q <= cfg_wr_data;
		end
	end

	assign en3       = !v_s3 || load_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= req_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Each stage folds about two frame bytes into the running CRC.
	always_ff @(posedge clk) begin
		if (en1) begin
			addr_s1 <= register_address;
			data_s1 <= write_data;
			node_s1 <= node_address_q;
			crc_s1  <= crc8_update(crc8_update(CRC_INIT, SYNC_BYTE), node_address_q);
		end
		if (en2) begin
			addr_s2 <= addr_s1;
			data_s2 <= data_s1;
			node_s2 <= node_s1;
			crc_s2  <= crc8_update(crc8_update(crc_s1, WRITE_FLAG | {1'b0, addr_s1}),
				data_s1[31:24]);
		end
		if (en3) begin
			addr_s3 <= addr_s2;
			data_s3 <= data_s2;
			node_s3 <= node_s2;
			crc_s3  <= crc8_update(crc8_update(crc_s2, data_s2[23:16]), data_s2[15:8]);
		end
	end

	always_comb begin
		load_frame.node_address     = node_s3;
		load_frame.register_address = addr_s3;
		load_frame.write_data       = data_s3;
		load_frame.crc              = crc8_update(crc_s3, data_s3[7:0]);
	end

	uwdf_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (v_s3),
		.load_frame  (load_frame),
		.load_ready  (load_ready),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

endmodule

/* tb/sv/uart_write_datagram_framer_test.sv */
module uart_write_datagram_framer_test;
	import uwdf_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'h00;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [6:0]  register_address = 7'h00;
	logic [31:0] write_data = 32'h0;
	logic        frame_valid;
	logic        frame_stall = 1'b0;
	logic [7:0]  frame_byte;
	logic        last_byte;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int          error_count = 0;
	logic [7:0]  node_address_model = 8'h00;
	frame_beat_t pending_frame_bytes[$];
	frame_beat_t oldest_beat;

	uart_write_datagram_framer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.register_address (register_address),
		.write_data       (write_data),
		.frame_valid      (frame_valid),
		.frame_stall      (frame_stall),
		.frame_byte       (frame_byte),
		.last_byte        (last_byte)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("uart_write_datagram_framer verification failed");
		$finish;
	end

	// CRC-8 over the seven header bytes, each byte fed in starting from its bit 0.
	function automatic logic [7:0] crc8_over_header(input logic [55:0] header);
		logic [7:0] crc;
		logic [7:0] cur;
		logic       feedback;
		crc = CRC_INIT;
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			cur = header[55 - 8 * i -: 8];
			for (int k = 0; k < 8; k++) begin
				feedback = crc[7] ^ cur[k];
				crc = {crc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
			end
		end
		return crc;
	endfunction

	function automatic void predict_write_frame(input logic [6:0] addr, input logic [31:0] data);
		logic [55:0] header;
		frame_beat_t beat;
		header = {SYNC_BYTE, node_address_model, WRITE_FLAG | {1'b0, addr}, data};
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			beat.value = header[55 - 8 * i -: 8];
			beat.last = 1'b0;
			pending_frame_bytes.push_back(beat);
		end
		beat.value = crc8_over_header(header);
		beat.last = 1'b1;
		pending_frame_bytes.push_back(beat);
	endfunction

	// Receiver: random stall and a check of every accepted byte beat.
	always @(posedge clk) begin
		frame_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && frame_valid && !frame_stall) begin
			if (pending_frame_bytes.size() == 0) begin
				$error("frame_byte: no beat expected, actual %02h", frame_byte);
				error_count++;
			end else begin
				oldest_beat = pending_frame_bytes.pop_front();
				if (frame_byte !== oldest_beat.value) begin
					$error("frame_byte: expected %02h, actual %02h", oldest_beat.value, frame_byte);
					error_count++;
				end
				if (last_byte !== oldest_beat.last) begin
					$error("last_byte: expected %0b, actual %0b", oldest_beat.last, last_byte);
					error_count++;
				end
			end
		end
	end

	// Called at a rising edge; returns at the edge that accepts the beat, with valid still high.
	task automatic send_write_request(input logic [6:0] addr, input logic [31:0] data);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			register_address <= 7'($urandom);
			write_data <= $urandom;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		register_address <= addr;
		write_data <= data;
		do @(posedge clk); while (req_stall);
		predict_write_frame(addr, data);
	endtask

	task automatic wait_frames_drained();
		req_valid <= 1'b0;
		while (pending_frame_bytes.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_node_address(input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		node_address_model = value;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 8'($urandom);
	endtask

	task automatic test_field_extremes();
		idle_pct = 0;
		stall_pct = 0;
		send_write_request(7'h00, 32'h0000_0000);
		send_write_request(7'h7F, 32'hFFFF_FFFF);
		send_write_request(7'h55, 32'hAAAA_AAAA);
		send_write_request(7'h2A, 32'h5555_5555);
		send_write_request(7'h40, 32'h8000_0000);
		send_write_request(7'h01, 32'h0000_0001);
		send_write_request(7'h12, 32'h0102_0304);
		send_write_request(7'h7F, 32'h0000_0000);
		wait_frames_drained();
	endtask

	task automatic test_node_address_extremes();
		write_node_address(8'hFF);
		send_write_request(7'h00, 32'h0000_0000);
		send_write_request(7'h7F, 32'hFFFF_FFFF);
		wait_frames_drained();
		write_node_address(8'h80);
		send_write_request(7'h33, 32'hDEAD_BEEF);
		wait_frames_drained();
		write_node_address(8'h00);
		send_write_request(7'h7F, 32'hFFFF_FFFF);
		wait_frames_drained();
	endtask

	task automatic test_random_traffic(input int count, input logic [7:0] node,
		input int unsigned sender_idle, input int unsigned receiver_stall);
		logic [31:0] data;
		write_node_address(node);
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(7))
				0: data = 32'h0000_0000;
				1: data = 32'hFFFF_FFFF;
				default: data = $urandom;
			endcase
			send_write_request(7'($urandom_range(127)), data);
		end
		wait_frames_drained();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_node_address_extremes();
		test_random_traffic(125, 8'($urandom), 0, 0);
		test_random_traffic(125, 8'h00, 84, 0);
		test_random_traffic(125, 8'hFF, 0, 84);
		test_random_traffic(125, 8'($urandom), 31, 31);
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_frame_bytes.size() == 0) begin
			$display("uart_write_datagram_framer verification clean");
		end else begin
			$display("uart_write_datagram_framer verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/uwdf_pkg.sv
rtl/uwdf_ser.sv
rtl/uart_write_datagram_framer.sv
tb/sv/uart_write_datagram_framer_test.sv
